// File: rtl/tccw_pkg.sv
// Shared types, command codes and constants for the text console cell writer.
`default_nettype none
package tccw_pkg;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int NUM_W    = 32;
    localparam int ADDR_W   = 12;
    localparam int ATTR_W   = 8;
    localparam int DIGITS   = 10;
    localparam int IDX_W    = 4;
    localparam int DIGIT_W  = 4;

    localparam logic [CMD_W-1:0] CMD_PUT_CHAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BACKSPACE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PUT_NUM   = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // controller -> datapath
    typedef struct packed {
        logic idle;   // waiting for a request
        logic load;   // latch the accepted request
        logic exec;   // carry out put char / backspace
        logic sub;    // subtract current power of ten
        logic skip;   // drop a leading zero digit
        logic emit;   // write the finished digit
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic req_valid;
        logic req_num;     // incoming request is put number
        logic need_write;  // latched put char / backspace makes a write
        logic ge;          // value >= current power of ten
        logic lead_zero;   // digit is a suppressed leading zero
        logic last_digit;  // units digit
        logic out_free;    // output register can take a write
    } stat_t;

    function automatic logic [NUM_W-1:0] pow10(input logic [IDX_W-1:0] idx);
        logic [NUM_W-1:0] p;
        case (idx)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tccw_if.sv
// Valid/ready channel interfaces: requests, cell writes and the attribute register.
`default_nettype none
interface tccw_req_if;
    import tccw_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [NUM_W-1:0]  number_value;
    modport source (output valid, output cmd, output char_code, output number_value,
                    input ready);
    modport sink   (input valid, input cmd, input char_code, input number_value,
                    output ready);
endinterface

interface tccw_cell_if;
    import tccw_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              last_write;
    modport source (output valid, output cell_address, output cell_char,
                    output cell_attr, output last_write, input ready);
    modport sink   (input valid, input cell_address, input cell_char,
                    input cell_attr, input last_write, output ready);
endinterface

interface tccw_cfg_if;
    import tccw_pkg::*;
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tccw_ctrl.sv
// Sequencing state machine for the text console cell writer.
`default_nettype none
module tccw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  tccw_pkg::stat_t     stat,
    output tccw_pkg::ctl_t      ctl
);
    import tccw_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_NUM  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctl.idle = 1'b1;
                if (stat.req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = stat.req_num ? S_NUM : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.need_write || stat.out_free)
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NUM:
            begin
                if (stat.ge)
                    ctl.sub = 1'b1;
                else if (stat.lead_zero)
                    ctl.skip = 1'b1;
                else if (stat.out_free)
                begin
                    ctl.emit = 1'b1;
                    if (stat.last_digit)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: rtl/tccw_dp.sv
// Cursor, decimal digit unit, attribute register and output register.
`default_nettype none
module tccw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tccw_req_if.sink        req,
    tccw_cell_if.source     wr,
    tccw_cfg_if.sink        cfg,
    input  tccw_pkg::ctl_t  ctl,
    output tccw_pkg::stat_t stat
);
    import tccw_pkg::*;

    localparam int CW = $clog2(COLUMNS + 1);
    localparam int RW = $clog2(ROWS);
    localparam int LW = RW + 9;

    logic [CMD_W-1:0]   cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [NUM_W-1:0]   val_reg,   val_next;
    logic [IDX_W-1:0]   idx_reg,   idx_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               lead_reg,  lead_next;
    logic [RW-1:0]      row_reg,   row_next;
    logic [CW-1:0]      col_reg,   col_next;
    logic [ATTR_W-1:0]  attr_reg;

    logic               cell_valid_reg, cell_valid_next;
    logic [ADDR_W-1:0]  cell_address_reg;
    logic [CHAR_W-1:0]  cell_char_reg;
    logic [ATTR_W-1:0]  cell_attr_reg;
    logic               cell_last_reg;

    logic [NUM_W-1:0]   pow;
    logic               out_free;
    logic               wrap;
    logic [RW-1:0]      row_adv;
    logic [RW-1:0]      put_row;
    logic [CW-1:0]      put_col;
    logic [RW-1:0]      a_row;
    logic [CW-1:0]      a_col;
    logic [LW-1:0]      lin;
    logic [LW:0]        addr_full;
    logic               is_bs;
    logic               ch_print;
    logic               wr_en;
    logic [CHAR_W-1:0]  wr_char;
    logic               wr_last;

    assign pow      = pow10(idx_reg);
    assign out_free = !cell_valid_reg || wr.ready;
    assign ch_print = (char_reg != CH_NUL) && (char_reg != CH_NEWLINE);
    assign is_bs    = (cmd_reg == CMD_BACKSPACE);

    assign stat.req_valid  = req.valid;
    assign stat.req_num    = (req.cmd == CMD_PUT_NUM);
    assign stat.need_write = ((cmd_reg == CMD_PUT_CHAR) && ch_print) ||
                             (is_bs && (col_reg != '0));
    assign stat.ge         = (val_reg >= pow);
    assign stat.lead_zero  = lead_reg && (digit_reg == '0) && (idx_reg != '0);
    assign stat.last_digit = (idx_reg == '0);
    assign stat.out_free   = out_free;

    assign req.ready = ctl.idle;
    assign cfg.ready = 1'b1;

    // cursor after a line wrap
    assign row_adv = (row_reg == RW'(ROWS - 1)) ? '0 : row_reg + 1'b1;
    assign wrap    = (col_reg >= CW'(COLUMNS));
    assign put_row = wrap ? row_adv : row_reg;
    assign put_col = wrap ? '0 : col_reg;

    // write address; backspace writes at the column to the left on the same row
    assign a_row     = (ctl.exec && is_bs) ? row_reg : put_row;
    assign a_col     = (ctl.exec && is_bs) ? col_reg - 1'b1 : put_col;
    assign lin       = LW'(a_row) * LW'(COLUMNS) + LW'(a_col);
    assign addr_full = {lin, 1'b0};

    always_comb
    begin
        val_next   = val_reg;
        idx_next   = idx_reg;
        digit_next = digit_reg;
        lead_next  = lead_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        wr_en      = 1'b0;
        wr_char    = CH_SPACE;
        wr_last    = 1'b1;

        if (ctl.load)
        begin
            val_next   = req.number_value;
            idx_next   = IDX_W'(DIGITS - 1);
            digit_next = '0;
            lead_next  = 1'b1;
        end
        if (ctl.sub)
        begin
            val_next   = val_reg - pow;
            digit_next = digit_reg + 1'b1;
        end
        if (ctl.skip)
            idx_next = idx_reg - 1'b1;
        if (ctl.emit)
        begin
            wr_en      = 1'b1;
            wr_char    = CH_ZERO | {4'b0, digit_reg};
            wr_last    = (idx_reg == '0);
            row_next   = put_row;
            col_next   = put_col + 1'b1;
            idx_next   = idx_reg - 1'b1;
            digit_next = '0;
            lead_next  = 1'b0;
        end
        if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_PUT_CHAR:
                begin
                    if (char_reg == CH_NEWLINE)
                    begin
                        row_next = row_adv;
                        col_next = '0;
                    end
                    else if (char_reg != CH_NUL)
                    begin
                        wr_en    = 1'b1;
                        wr_char  = char_reg;
                        row_next = put_row;
                        col_next = put_col + 1'b1;
                    end
                end
                CMD_BACKSPACE:
                begin
                    if (col_reg != '0)
                    begin
                        wr_en    = 1'b1;
                        wr_char  = CH_SPACE;
                        col_next = col_reg - 1'b1;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end

        if (wr_en)
            cell_valid_next = 1'b1;
        else if (wr.ready)
            cell_valid_next = 1'b0;
        else
            cell_valid_next = cell_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            attr_reg       <= ATTR_RESET;
            cell_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            cell_valid_reg <= cell_valid_next;
            if (cfg.valid)
                attr_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        digit_reg <= digit_next;
        lead_reg  <= lead_next;
        if (ctl.load)
        begin
            cmd_reg  <= req.cmd;
            char_reg <= req.char_code;
        end
        if (wr_en)
        begin
            cell_address_reg <= ADDR_W'(addr_full);
            cell_char_reg    <= wr_char;
            cell_attr_reg    <= attr_reg;
            cell_last_reg    <= wr_last;
        end
    end

    assign wr.valid        = cell_valid_reg;
    assign wr.cell_address = cell_address_reg;
    assign wr.cell_char    = cell_char_reg;
    assign wr.cell_attr    = cell_attr_reg;
    assign wr.last_write   = cell_last_reg;

endmodule
`default_nettype wire

// File: rtl/text_console_cell_writer.sv
// Top level of the text console cell writer: controller plus datapath.
// Put char / backspace: accept, then execute; a write waits for a free output register.
// Put number: accept, then per power of ten one subtract step per unit of the digit and one skip
//   or write step, paced by the single shared compare/subtract unit and held by output stalls.
// Output: the cell write is visible the cycle after the execute or digit step.
// Reset (rst_n low, async): cursor at row 0 column 0, attribute 0x07, no write pending.
`default_nettype none
module text_console_cell_writer #(
    parameter int COLUMNS = 80,   // cells per row, 2..255
    parameter int ROWS    = 25    // rows on screen, 2..63; COLUMNS*ROWS at most 2048
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tccw_req_if.sink     req,    // command requests
    tccw_cell_if.source  wr,     // character cell writes
    tccw_cfg_if.sink     cfg     // attribute register writes
);
    import tccw_pkg::*;

    // Command and status between the sequencer and the datapath.
    ctl_t  ctl;
    stat_t stat;

    // The controller walks each request: idle/accept, then either a single
    // execute step (put char, backspace, unknown command) or the digit loop
    // for put number. In the digit loop it subtracts the current power of
    // ten while the value allows, drops leading zeros, and writes each digit
    // once the output register is free. The output register lets a new
    // request be taken while the last cell write is still waiting.
    tccw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // The datapath holds the cursor, the latched request, the digit unit,
    // the attribute register (written any time, always ready) and the
    // output register. Full lines wrap before a write; newline moves the
    // cursor without a write; the row wraps to 0 after the last row.
    tccw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .wr    (wr),
        .cfg   (cfg),
        .ctl   (ctl),
        .stat  (stat)
    );

endmodule
`default_nettype wire
